### rtl/core/crlf_line_and_capture_receiver_top_assert.svh
// assertion macros for the receiver rtl
`ifndef CRLF_LINE_AND_CAPTURE_RECEIVER_TOP_ASSERT_SVH
`define CRLF_LINE_AND_CAPTURE_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication
`define CRLF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crlf receiver check failed");

// next-cycle implication
`define CRLF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crlf receiver check failed");

`endif

### rtl/core/crlf_pkg.sv
// ----------------------------------------------------------------------------
// crlf_pkg
// shared constants, types and reply tables of the crlf line and capture receiver
// ----------------------------------------------------------------------------
package crlf_pkg;

   localparam int BUF_BYTES = 64;
   localparam int IDX_W     = $clog2(BUF_BYTES);
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(BUF_BYTES - 1);

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_ARM  = 1'b1;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;

   localparam logic [2:0] KIND_OTHER = 3'd0;
   localparam logic [2:0] KIND_CONN  = 3'd1;
   localparam logic [2:0] KIND_GOTIP = 3'd2;
   localparam logic [2:0] KIND_OK    = 3'd3;
   localparam logic [2:0] KIND_DISC  = 3'd4;

   localparam int REP_CONN_LEN  = 14;
   localparam int REP_GOTIP_LEN = 11;
   localparam int REP_OK_LEN    = 2;
   localparam int REP_DISC_LEN  = 15;

   localparam logic [8*REP_CONN_LEN-1:0]  REP_CONN  = "WIFI CONNECTED";
   localparam logic [8*REP_GOTIP_LEN-1:0] REP_GOTIP = "WIFI GOT IP";
   localparam logic [8*REP_OK_LEN-1:0]    REP_OK    = "OK";
   localparam logic [8*REP_DISC_LEN-1:0]  REP_DISC  = "WIFI DISCONNECT";

   typedef enum logic [0:0] {
      S_IDLE,
      S_CMP
   } ctrl_state_type;

   typedef struct packed {
      logic step;
      logic cmp_en;
      logic cmp_finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_cmp;
      logic cmp_last;
   } dp_sts_type;

   // character idx of the reply selected by kind
   function automatic logic [7:0] reply_char(input logic [2:0] kind, input logic [3:0] idx);
      logic [7:0] ch;
      int         i;
      ch = 8'h00;
      i  = int'(idx);
      unique case (kind)
         KIND_CONN: begin
            if (i < REP_CONN_LEN) ch = REP_CONN[8*(REP_CONN_LEN-1-i) +: 8];
         end
         KIND_GOTIP: begin
            if (i < REP_GOTIP_LEN) ch = REP_GOTIP[8*(REP_GOTIP_LEN-1-i) +: 8];
         end
         KIND_OK: begin
            if (i < REP_OK_LEN) ch = REP_OK[8*(REP_OK_LEN-1-i) +: 8];
         end
         KIND_DISC: begin
            if (i < REP_DISC_LEN) ch = REP_DISC[8*(REP_DISC_LEN-1-i) +: 8];
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

### rtl/core/crlf_ram.sv
// ----------------------------------------------------------------------------
// crlf_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module crlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/crlf_ctrl.sv
// ----------------------------------------------------------------------------
// crlf_ctrl
// handshake and sequencing for the receiver: accept, reply compare walk, result
// ----------------------------------------------------------------------------
module crlf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  crlf_pkg::dp_sts_type  sts,
   output crlf_pkg::ctrl_cmd_type cmd
);

   crlf_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crlf_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register is free when empty or being taken this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == crlf_pkg::S_IDLE) && rsp_free);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      cmd.step       = 1'b0;
      cmd.cmp_en     = 1'b0;
      cmd.cmp_finish = 1'b0;
      unique case (state_ff)
         crlf_pkg::S_IDLE: begin
            cmd.step = accept;
            if (accept) begin
               if (sts.need_cmp) begin
                  state_in = crlf_pkg::S_CMP;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         crlf_pkg::S_CMP: begin
            cmd.cmp_en = 1'b1;
            if (sts.cmp_last) begin
               cmd.cmp_finish = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = crlf_pkg::S_IDLE;
            end
         end
         default: state_in = crlf_pkg::S_IDLE;
      endcase
   end

endmodule

### rtl/core/crlf_datapath.sv
// ----------------------------------------------------------------------------
// crlf_datapath
// line and capture state, line store, reply compare walk and result register
// ----------------------------------------------------------------------------
module crlf_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  crlf_pkg::ctrl_cmd_type cmd,
   output crlf_pkg::dp_sts_type   sts,
   input  logic                   req_command,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_line_done,
   output logic [2:0]             rsp_line_kind,
   output logic [5:0]             rsp_line_length,
   output logic                   rsp_link_up,
   output logic                   rsp_data_mode,
   output logic                   rsp_resyncing,
   output logic                   rsp_capture_done,
   output logic [5:0]             rsp_capture_length,
   output logic                   rsp_write_enable,
   output logic [5:0]             rsp_write_index,
   output logic [7:0]             rsp_write_data
);

   localparam int IW = crlf_pkg::IDX_W;

   // block state
   logic [IW-1:0] count_ff, count_in;
   logic          line_ready_ff, line_ready_in;
   logic          resync_ff, resync_in;
   logic          mode_ff;
   logic          link_ff;
   logic          armed_ff, armed_in;
   logic          active_ff, active_in;
   logic          prev_cr_ff, prev_cr_in;

   // compare walk
   logic [3:0] idx_ff;
   logic [3:0] cmp_len_ff;
   logic [2:0] cand_ff;
   logic       cmp_ok_ff;

   // result register
   logic       rsp_line_done_ff;
   logic [2:0] rsp_line_kind_ff;
   logic [5:0] rsp_line_length_ff;
   logic       rsp_link_up_ff;
   logic       rsp_data_mode_ff;
   logic       rsp_resyncing_ff;
   logic       rsp_capture_done_ff;
   logic [5:0] rsp_capture_length_ff;
   logic       rsp_write_enable_ff;
   logic [5:0] rsp_write_index_ff;
   logic [7:0] rsp_write_data_ff;

   // step results
   logic [IW-1:0] pos;
   logic          s_line_end;
   logic [IW-1:0] s_len;
   logic [2:0]    s_cand;
   logic          s_cdone;
   logic [IW-1:0] s_clen;
   logic          s_we;
   logic [IW-1:0] s_widx;
   logic [7:0]    s_wdata;

   logic [7:0] ram_rdata;
   logic       hit;
   logic       fin_ok;
   logic       fin_link;
   logic       fin_mode;
   logic [2:0] fin_kind;

   crlf_ram #(
      .WIDTH (8),
      .DEPTH (crlf_pkg::BUF_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (s_we && cmd.step),
      .wr_addr (s_widx),
      .wr_data (s_wdata),
      .rd_addr (IW'(idx_ff)),
      .rd_data (ram_rdata)
   );

   always_comb begin
      count_in      = count_ff;
      line_ready_in = line_ready_ff;
      resync_in     = resync_ff;
      armed_in      = armed_ff;
      active_in     = active_ff;
      prev_cr_in    = prev_cr_ff;
      pos           = '0;
      s_line_end    = 1'b0;
      s_len         = '0;
      s_cdone       = 1'b0;
      s_clen        = '0;
      s_we          = 1'b0;
      s_widx        = '0;
      s_wdata       = 8'h00;
      if (req_command == crlf_pkg::CMD_ARM) begin
         armed_in = 1'b1;
      end else if (!mode_ff) begin
         pos           = line_ready_ff ? '0 : count_ff;
         line_ready_in = 1'b0;
         count_in      = pos;
         s_we          = 1'b1;
         s_widx        = pos;
         s_wdata       = req_rx_byte;
         prev_cr_in    = (req_rx_byte == crlf_pkg::CH_CR);
         if (resync_ff) begin
            if (req_rx_byte == crlf_pkg::CH_LF) resync_in = 1'b0;
         end else if (req_rx_byte == crlf_pkg::CH_LF && pos != '0) begin
            count_in = '0;
            if (prev_cr_ff) begin
               s_line_end    = 1'b1;
               s_len         = pos - IW'(1);
               line_ready_in = 1'b1;
            end else begin
               resync_in = 1'b1;
            end
         end else if (pos == crlf_pkg::LAST_POS) begin
            count_in  = '0;
            resync_in = 1'b1;
         end else begin
            count_in = pos + IW'(1);
         end
      end else if (armed_ff) begin
         if (active_ff) begin
            if (req_rx_byte == crlf_pkg::CH_M) begin
               s_we      = 1'b1;
               s_widx    = count_ff;
               s_wdata   = 8'h00;
               s_cdone   = 1'b1;
               s_clen    = count_ff;
               count_in  = '0;
               active_in = 1'b0;
               armed_in  = 1'b0;
            end else if (req_rx_byte != crlf_pkg::CH_CR && req_rx_byte != crlf_pkg::CH_LF &&
                         req_rx_byte != crlf_pkg::CH_PLUS && count_ff != crlf_pkg::LAST_POS) begin
               s_we     = 1'b1;
               s_widx   = count_ff;
               s_wdata  = req_rx_byte;
               count_in = count_ff + IW'(1);
            end
         end
         if (req_rx_byte == crlf_pkg::CH_COLON) active_in = 1'b1;
      end
   end

   // only one reply can match a given length
   always_comb begin
      s_cand = crlf_pkg::KIND_OTHER;
      if (s_len == IW'(crlf_pkg::REP_CONN_LEN))  s_cand = crlf_pkg::KIND_CONN;
      if (s_len == IW'(crlf_pkg::REP_GOTIP_LEN)) s_cand = crlf_pkg::KIND_GOTIP;
      if (s_len == IW'(crlf_pkg::REP_OK_LEN))    s_cand = crlf_pkg::KIND_OK;
      if (s_len == IW'(crlf_pkg::REP_DISC_LEN))  s_cand = crlf_pkg::KIND_DISC;
   end

   assign sts.need_cmp = s_line_end && (s_cand != crlf_pkg::KIND_OTHER);
   assign sts.cmp_last = (idx_ff == cmp_len_ff);

   // read data of the previous cycle belongs to character idx_ff - 1
   assign hit    = (ram_rdata == crlf_pkg::reply_char(cand_ff, idx_ff - 4'd1));
   assign fin_ok = cmp_ok_ff && hit;

   always_comb begin
      fin_link = link_ff;
      fin_mode = mode_ff;
      fin_kind = fin_ok ? cand_ff : crlf_pkg::KIND_OTHER;
      if (fin_ok) begin
         unique case (cand_ff)
            crlf_pkg::KIND_CONN: fin_link = 1'b1;
            crlf_pkg::KIND_DISC: fin_link = 1'b0;
            crlf_pkg::KIND_OK:   fin_mode = 1'b1;
            default:             fin_link = link_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         line_ready_ff <= 1'b0;
         resync_ff     <= 1'b0;
         mode_ff       <= 1'b0;
         link_ff       <= 1'b0;
         armed_ff      <= 1'b0;
         active_ff     <= 1'b0;
         prev_cr_ff    <= 1'b0;
      end else begin
         if (cmd.step) begin
            count_ff      <= count_in;
            line_ready_ff <= line_ready_in;
            resync_ff     <= resync_in;
            armed_ff      <= armed_in;
            active_ff     <= active_in;
            prev_cr_ff    <= prev_cr_in;
         end
         if (cmd.cmp_finish) begin
            link_ff <= fin_link;
            mode_ff <= fin_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         idx_ff     <= 4'd0;
         cmp_ok_ff  <= 1'b1;
         cand_ff    <= s_cand;
         cmp_len_ff <= s_len[3:0];
      end else if (cmd.cmp_en) begin
         idx_ff <= idx_ff + 4'd1;
         if (idx_ff != 4'd0) cmp_ok_ff <= cmp_ok_ff && hit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rsp_line_done_ff      <= s_line_end;
         rsp_line_kind_ff      <= crlf_pkg::KIND_OTHER;
         rsp_line_length_ff    <= 6'(s_len);
         rsp_link_up_ff        <= link_ff;
         rsp_data_mode_ff      <= mode_ff;
         rsp_resyncing_ff      <= resync_in;
         rsp_capture_done_ff   <= s_cdone;
         rsp_capture_length_ff <= 6'(s_clen);
         rsp_write_enable_ff   <= s_we;
         rsp_write_index_ff    <= 6'(s_widx);
         rsp_write_data_ff     <= s_wdata;
      end else if (cmd.cmp_finish) begin
         rsp_line_kind_ff <= fin_kind;
         rsp_link_up_ff   <= fin_link;
         rsp_data_mode_ff <= fin_mode;
      end
   end

   assign rsp_line_done      = rsp_line_done_ff;
   assign rsp_line_kind      = rsp_line_kind_ff;
   assign rsp_line_length    = rsp_line_length_ff;
   assign rsp_link_up        = rsp_link_up_ff;
   assign rsp_data_mode      = rsp_data_mode_ff;
   assign rsp_resyncing      = rsp_resyncing_ff;
   assign rsp_capture_done   = rsp_capture_done_ff;
   assign rsp_capture_length = rsp_capture_length_ff;
   assign rsp_write_enable   = rsp_write_enable_ff;
   assign rsp_write_index    = rsp_write_index_ff;
   assign rsp_write_data     = rsp_write_data_ff;

endmodule

### rtl/core/crlf_line_and_capture_receiver_top.sv
// ----------------------------------------------------------------------------
// crlf_line_and_capture_receiver_top
// serial reply line framer with data-mode payload capture
// ----------------------------------------------------------------------------
// usage:
//   req_ channel carries one transaction per received byte (req_command = 0)
//   or per arm event (req_command = 1). rsp_ channel returns exactly one
//   result transaction for each request, in order.
//   for most transactions the result is in the output register on the cycle
//   after acceptance and, while rsp_stall is low, a new request can be taken
//   every cycle. a byte that closes a line of length 2, 11, 14 or 15 walks
//   the stored line through the line store read port, one character a cycle;
//   no request is taken meanwhile.
//   while rsp_stall holds a result, req_stall is raised and the result holds.
//   reset clears framing, mode, link and capture state and drops any pending
//   result; the line store contents are undefined until written.
// ----------------------------------------------------------------------------
`include "crlf_line_and_capture_receiver_top_assert.svh"

module crlf_line_and_capture_receiver_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_command,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_line_done,
   output logic [2:0] rsp_line_kind,
   output logic [5:0] rsp_line_length,
   output logic       rsp_link_up,
   output logic       rsp_data_mode,
   output logic       rsp_resyncing,
   output logic       rsp_capture_done,
   output logic [5:0] rsp_capture_length,
   output logic       rsp_write_enable,
   output logic [5:0] rsp_write_index,
   output logic [7:0] rsp_write_data
);

   crlf_pkg::ctrl_cmd_type ctrl_cmd;
   crlf_pkg::dp_sts_type   dp_sts;

   crlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (dp_sts),
      .cmd       (ctrl_cmd)
   );

   crlf_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctrl_cmd),
      .sts                (dp_sts),
      .req_command        (req_command),
      .req_rx_byte        (req_rx_byte),
      .rsp_line_done      (rsp_line_done),
      .rsp_line_kind      (rsp_line_kind),
      .rsp_line_length    (rsp_line_length),
      .rsp_link_up        (rsp_link_up),
      .rsp_data_mode      (rsp_data_mode),
      .rsp_resyncing      (rsp_resyncing),
      .rsp_capture_done   (rsp_capture_done),
      .rsp_capture_length (rsp_capture_length),
      .rsp_write_enable   (rsp_write_enable),
      .rsp_write_index    (rsp_write_index),
      .rsp_write_data     (rsp_write_data)
   );

   // no request may slip in during a compare walk
   `CRLF_ASSERT_NOW(a_walk_blocks_req, clock, reset, ctrl_cmd.cmp_en, req_stall)
   // the walk always ends in a presented result
   `CRLF_ASSERT_NEXT(a_finish_presents, clock, reset, ctrl_cmd.cmp_finish, rsp_valid)
   `CRLF_ASSERT_NOW(a_kind_only_on_line, clock, reset, rsp_valid && !rsp_line_done, rsp_line_kind == crlf_pkg::KIND_OTHER)
   `CRLF_ASSERT_NOW(a_ok_enters_data, clock, reset, rsp_valid && rsp_line_kind == crlf_pkg::KIND_OK, rsp_data_mode)

endmodule
